// ===== hw/rtl/sfwc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfwc_pkg
// Shared types, codes and the built-in gain table of the state feedback
// wrench controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfwc_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DISABLED = 2'd1;
    localparam logic [1:0] STATUS_LIMITS   = 2'd2;
    localparam logic [1:0] STATUS_LENGTH   = 2'd3;

    // Configuration register indexes
    localparam int         CFG_INDEX_W      = 3;
    localparam logic [2:0] CFG_MASS         = 3'd0;
    localparam logic [2:0] CFG_GRAVITY      = 3'd1;
    localparam logic [2:0] CFG_FORCE_MIN    = 3'd2;
    localparam logic [2:0] CFG_FORCE_MAX    = 3'd3;
    localparam logic [2:0] CFG_TORQUE_LIMIT = 3'd4;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int ACC_W    = 56;
    localparam int CMD_MAX  = 4;
    localparam int CMD_IDX_W = 2;

    // Built-in gains, Q16.16, row-major 4 commands by 12 state elements
    localparam int DEF_ROWS = 4;
    localparam int DEF_COLS = 12;
    localparam logic signed [31:0] DEF_GAINS [DEF_ROWS*DEF_COLS] = '{
        32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
        32'sd0, 32'sd0, 32'sd6689565, 32'sd0, 32'sd0, 32'sd10535283,
        -32'sd34173857, 32'sd0, 32'sd0, -32'sd708183, 32'sd0, 32'sd0,
        32'sd0, -32'sd28673239, 32'sd0, 32'sd0, -32'sd68814941, 32'sd0,
        32'sd0, -32'sd34173857, 32'sd0, 32'sd0, -32'sd708183, 32'sd0,
        32'sd28673239, 32'sd0, 32'sd0, 32'sd68814941, 32'sd0, 32'sd0,
        32'sd0, 32'sd0, -32'sd8230690, 32'sd0, 32'sd0, -32'sd1655532,
        32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0
    };

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FF,
        ST_OUT
    } sfwc_state_t;

    // Gain for command c and element i, converted from Q16 to fb fraction bits.
    // Above Q16 the shift saturates; below Q16 it rounds half up.
    function automatic logic signed [31:0] gain_lookup(input int c, input int i,
                                                       input int fb);
        longint g;
        longint r;
        begin
            g = 64'sd0;
            if (c < DEF_ROWS && i < DEF_COLS)
            begin
                g = longint'(DEF_GAINS[c*DEF_COLS + i]);
            end
            if (fb >= 16)
            begin
                r = g <<< (fb - 16);
                if (r > 64'sd2147483647)
                begin
                    r = 64'sd2147483647;
                end
                else if (r < -64'sd2147483648)
                begin
                    r = -64'sd2147483648;
                end
            end
            else
            begin
                r = (g + (64'sd1 <<< (15 - fb))) >>> (16 - fb);
            end
            return 32'(r);
        end
    endfunction

endpackage

// ===== hw/rtl/state_feedback_wrench_controller.sv =====
// ----------------------------------------------------------------------------
// state_feedback_wrench_controller
// Datapath: each element runs one multiply per command in ST_MAC through one
// shared 32x32 multiplier; the last element adds a feedforward multiply
// (ST_FF) and an output state (ST_OUT) that holds while a result waits. An
// element past STATE_COUNT skips ST_MAC. A new element is taken only in
// ST_IDLE, once the multiplies of the previous one are done.
// Reset: sums, count and config registers return to defaults; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module state_feedback_wrench_controller #(
    parameter int STATE_COUNT   = 12,
    parameter int COMMAND_COUNT = 4,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write_en,
    input  logic [sfwc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sfwc_pkg::DATA_W-1:0]       cfg_data,
    // element input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              enable,
    input  logic signed [sfwc_pkg::DATA_W-1:0] state_value,
    input  logic signed [sfwc_pkg::DATA_W-1:0] reference_value,
    input  logic                              last,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sfwc_pkg::DATA_W-1:0] thrust_force,
    output logic signed [sfwc_pkg::DATA_W-1:0] torque_first,
    output logic signed [sfwc_pkg::DATA_W-1:0] torque_second,
    output logic signed [sfwc_pkg::DATA_W-1:0] torque_third,
    output logic                              saturated,
    output logic [1:0]                        status
);

    import sfwc_pkg::*;

    localparam int CW = $clog2(STATE_COUNT + 1);
    localparam int EW = ACC_W + 1;
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRACTION_BITS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sfwc_state_t               state_reg, state_next;
    logic signed [31:0]        mass_reg, gravity_reg, force_min_reg;
    logic signed [31:0]        force_max_reg, torque_limit_reg;
    logic signed [ACC_W-1:0]   sums_reg [CMD_MAX];
    logic [CW-1:0]             count_reg;
    logic                      ovf_reg;
    logic [CW-1:0]             idx_reg;
    logic [CMD_IDX_W-1:0]      cmd_reg;
    logic signed [31:0]        err_reg;
    logic                      last_reg;
    logic [1:0]                status_reg;
    logic signed [63:0]        prod_reg;
    logic                      prod_acc_reg;
    logic [CMD_IDX_W-1:0]      prod_cmd_reg;
    logic                      out_valid_reg;
    logic signed [31:0]        thrust_reg, tq1_reg, tq2_reg, tq3_reg;
    logic                      sat_reg;
    logic [1:0]                out_status_reg;

    // ------------------------------------------------------------------
    // Sequencer controls
    // ------------------------------------------------------------------
    logic in_fire;
    logic mac_en;
    logic ff_en;
    logic out_load;
    logic cmd_done;
    logic skip_elem;

    assign in_fire   = in_valid && in_ready;
    assign skip_elem = (count_reg >= CW'(STATE_COUNT));
    assign cmd_done  = (cmd_reg == CMD_IDX_W'(COMMAND_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!skip_elem)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (last)
                    begin
                        state_next = ST_FF;
                    end
                end
            end
            ST_MAC:
            begin
                if (cmd_done)
                begin
                    state_next = last_reg ? ST_FF : ST_IDLE;
                end
            end
            ST_FF:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        mac_en   = 1'b0;
        ff_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_MAC:  mac_en   = 1'b1;
            ST_FF:   ff_en    = 1'b1;
            ST_OUT:  out_load = !out_valid_reg || out_ready;
            default: in_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_out;

    assign mul_a   = ff_en ? mass_reg : gain_lookup(int'(cmd_reg), int'(idx_reg),
                                                    FRACTION_BITS);
    assign mul_b   = ff_en ? gravity_reg : err_reg;
    assign mul_out = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Rounding and saturating accumulate
    // ------------------------------------------------------------------
    logic signed [63:0]     prod_rnd;
    logic signed [EW-1:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;

    assign prod_rnd = (prod_reg + RND_HALF) >>> FRACTION_BITS;
    assign acc_sum  = EW'(sums_reg[prod_cmd_reg]) + $signed(prod_rnd[EW-1:0]);

    always_comb
    begin
        if (acc_sum[EW-1] != acc_sum[EW-2])
        begin
            acc_sat = acc_sum[EW-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                    : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Element error, saturated to 32 bits
    // ------------------------------------------------------------------
    logic signed [32:0] diff;
    logic signed [31:0] err_sat;

    assign diff = 33'(state_value) - 33'(reference_value);
    always_comb
    begin
        if (diff[32] != diff[31])
        begin
            err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            err_sat = diff[31:0];
        end
    end

    // status of a vector, checked on its last element
    logic [1:0] status_calc;
    always_comb
    begin
        if (!enable)
        begin
            status_calc = STATUS_DISABLED;
        end
        else if (force_max_reg < force_min_reg || torque_limit_reg <= 32'sd0)
        begin
            status_calc = STATUS_LIMITS;
        end
        else if (ovf_reg || count_reg != CW'(STATE_COUNT - 1))
        begin
            status_calc = STATUS_LENGTH;
        end
        else
        begin
            status_calc = STATUS_OK;
        end
    end

    // ------------------------------------------------------------------
    // Feedforward, clamps and saturation flag
    // ------------------------------------------------------------------
    logic signed [EW-1:0] thrust_raw;
    logic signed [EW-1:0] f_min_x, f_max_x, t_pos_x, t_neg_x;
    logic signed [EW-1:0] tq_raw [3];
    logic signed [31:0]   thrust_cl;
    logic signed [31:0]   tq_cl [3];
    logic                 sat_any;

    assign thrust_raw = $signed(prod_rnd[EW-1:0]) + EW'(sums_reg[0]);
    assign f_min_x    = EW'(force_min_reg);
    assign f_max_x    = EW'(force_max_reg);
    assign t_pos_x    = EW'(torque_limit_reg);
    assign t_neg_x    = -EW'(torque_limit_reg);

    always_comb
    begin
        sat_any = 1'b0;
        if (thrust_raw < f_min_x)
        begin
            thrust_cl = force_min_reg;
            sat_any   = 1'b1;
        end
        else if (thrust_raw > f_max_x)
        begin
            thrust_cl = force_max_reg;
            sat_any   = 1'b1;
        end
        else
        begin
            thrust_cl = thrust_raw[31:0];
        end
        for (int k = 0; k < 3; k++)
        begin
            tq_raw[k] = EW'(sums_reg[k+1]);
            if (tq_raw[k] < t_neg_x)
            begin
                tq_cl[k] = t_neg_x[31:0];
                sat_any  = 1'b1;
            end
            else if (tq_raw[k] > t_pos_x)
            begin
                tq_cl[k] = torque_limit_reg;
                sat_any  = 1'b1;
            end
            else
            begin
                tq_cl[k] = tq_raw[k][31:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg         <= 32'sd65536;
            gravity_reg      <= 32'sd642253;
            force_min_reg    <= 32'sd0;
            force_max_reg    <= 32'sd1638400;
            torque_limit_reg <= 32'sd524288;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MASS:         mass_reg         <= cfg_data;
                CFG_GRAVITY:      gravity_reg      <= cfg_data;
                CFG_FORCE_MIN:    force_min_reg    <= cfg_data;
                CFG_FORCE_MAX:    force_max_reg    <= cfg_data;
                CFG_TORQUE_LIMIT: torque_limit_reg <= cfg_data;
                default:          mass_reg         <= mass_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            cmd_reg       <= '0;
            last_reg      <= 1'b0;
            prod_acc_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CMD_MAX; k++)
            begin
                sums_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // element transfer: count it or flag the overflow; the last one clears both
            if (in_fire)
            begin
                last_reg <= last;
                cmd_reg  <= '0;
                if (last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else if (skip_elem)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            if (mac_en)
            begin
                cmd_reg <= cmd_reg + CMD_IDX_W'(1);
            end

            // accumulate the pending product
            prod_acc_reg <= mac_en;
            if (prod_acc_reg)
            begin
                sums_reg[prod_cmd_reg] <= acc_sat;
            end

            // result register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                for (int k = 0; k < CMD_MAX; k++)
                begin
                    sums_reg[k] <= '0;
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            err_reg    <= err_sat;
            idx_reg    <= count_reg;
            status_reg <= status_calc;
        end
        if (mac_en || ff_en)
        begin
            prod_reg     <= mul_out;
            prod_cmd_reg <= cmd_reg;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            if (status_reg == STATUS_OK)
            begin
                thrust_reg <= thrust_cl;
                tq1_reg    <= tq_cl[0];
                tq2_reg    <= tq_cl[1];
                tq3_reg    <= tq_cl[2];
                sat_reg    <= sat_any;
            end
            else
            begin
                thrust_reg <= '0;
                tq1_reg    <= '0;
                tq2_reg    <= '0;
                tq3_reg    <= '0;
                sat_reg    <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign thrust_force  = thrust_reg;
    assign torque_first  = tq1_reg;
    assign torque_second = tq2_reg;
    assign torque_third  = tq3_reg;
    assign saturated     = sat_reg;
    assign status        = out_status_reg;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the state feedback wrench controller: a queue-fed
// driver streams state/reference elements, a monitor predicts each wrench
// from its own gain table and copy of the limits, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import sfwc_pkg::*;

    localparam int     STATE_COUNT  = 12;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     PHASE_ITEMS  = 125;
    localparam longint ACC_HI       = 64'sd36028797018963967;
    localparam longint ACC_LO       = -ACC_HI - 64'sd1;
    localparam longint WORD_HI      = 64'sd2147483647;
    localparam longint WORD_LO      = -64'sd2147483648;

    // Built-in feedback gains, Q16.16, command-major
    localparam int FEEDBACK_GAINS [4*STATE_COUNT] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 6689565, 0, 0, 10535283,
        -34173857, 0, 0, -708183, 0, 0, 0, -28673239, 0, 0, -68814941, 0,
        0, -34173857, 0, 0, -708183, 0, 28673239, 0, 0, 68814941, 0, 0,
        0, 0, -8230690, 0, 0, -1655532, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic              enable;
        logic [31:0]       state_v;
        logic [31:0]       ref_v;
        logic              last;
    } element_t;

    typedef struct {
        logic signed [31:0] thrust;
        logic signed [31:0] tq_first;
        logic signed [31:0] tq_second;
        logic signed [31:0] tq_third;
        logic               sat;
        logic [1:0]         code;
    } wrench_t;

    // DUT signals
    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    cfg_write_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index       = '0;
    logic [DATA_W-1:0]       cfg_data        = '0;
    logic                    in_valid        = 1'b0;
    logic                    in_ready;
    logic                    enable          = 1'b0;
    logic signed [DATA_W-1:0] state_value    = '0;
    logic signed [DATA_W-1:0] reference_value = '0;
    logic                    last            = 1'b0;
    logic                    out_valid;
    logic                    out_ready       = 1'b0;
    logic signed [DATA_W-1:0] thrust_force;
    logic signed [DATA_W-1:0] torque_first;
    logic signed [DATA_W-1:0] torque_second;
    logic signed [DATA_W-1:0] torque_third;
    logic                    saturated;
    logic [1:0]              status;

    // Bench state
    element_t pending_elements [$];
    wrench_t  expected_wrenches [$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       mismatches    = 0;
    int       stall_cycles  = 0;

    // Predicted controller state and limits
    longint      cmd_sum [4]    = '{0, 0, 0, 0};
    int          elem_count     = 0;
    bit          count_overflow = 1'b0;
    longint      lim_mass       = 65536;
    longint      lim_gravity    = 642253;
    longint      lim_force_min  = 0;
    longint      lim_force_max  = 1638400;
    longint      lim_torque     = 524288;

    state_feedback_wrench_controller dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint limit_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Clamp and note whether the limit was hit
    function automatic longint clip_to(longint v, longint lo, longint hi, inout bit hit);
        if (v < lo || v > hi)
        begin
            hit = 1'b1;
        end
        return limit_range(v, lo, hi);
    endfunction

    // Accumulate one element; on the last one queue the expected wrench
    task automatic take_element(input logic en, input logic signed [31:0] sv,
                                input logic signed [31:0] rv, input logic lst);
        longint  err;
        longint  prod;
        longint  res [4];
        int      idx;
        bit      hit;
        wrench_t w;
        idx = elem_count;
        hit = 1'b0;
        res = '{0, 0, 0, 0};
        if (idx >= STATE_COUNT)
        begin
            count_overflow = 1'b1;
        end
        else
        begin
            err = limit_range(longint'(sv) - longint'(rv), WORD_LO, WORD_HI);
            for (int c = 0; c < 4; c++)
            begin
                prod = longint'(FEEDBACK_GAINS[c*STATE_COUNT + idx]) * err;
                prod = (prod + 64'sd32768) >>> 16;
                cmd_sum[c] = limit_range(cmd_sum[c] + prod, ACC_LO, ACC_HI);
            end
            elem_count = idx + 1;
        end
        if (lst)
        begin
            if (!en)
                w.code = STATUS_DISABLED;
            else if (lim_force_max < lim_force_min || lim_torque <= 0)
                w.code = STATUS_LIMITS;
            else if (count_overflow || idx != STATE_COUNT - 1)
                w.code = STATUS_LENGTH;
            else
                w.code = STATUS_OK;
            if (w.code == STATUS_OK)
            begin
                res[0] = clip_to(((lim_mass * lim_gravity + 64'sd32768) >>> 16) + cmd_sum[0],
                                 lim_force_min, lim_force_max, hit);
                for (int c = 1; c < 4; c++)
                begin
                    res[c] = clip_to(cmd_sum[c], -lim_torque, lim_torque, hit);
                end
            end
            w.thrust    = 32'(res[0]);
            w.tq_first  = 32'(res[1]);
            w.tq_second = 32'(res[2]);
            w.tq_third  = 32'(res[3]);
            w.sat       = hit;
            expected_wrenches.push_back(w);
            cmd_sum        = '{0, 0, 0, 0};
            elem_count     = 0;
            count_overflow = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: track limit writes, check results, predict on input transfers
    always @(posedge clk)
    begin
        wrench_t w;
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MASS:         lim_mass      = longint'($signed(cfg_data));
                    CFG_GRAVITY:      lim_gravity   = longint'($signed(cfg_data));
                    CFG_FORCE_MIN:    lim_force_min = longint'($signed(cfg_data));
                    CFG_FORCE_MAX:    lim_force_max = longint'($signed(cfg_data));
                    CFG_TORQUE_LIMIT: lim_torque    = longint'($signed(cfg_data));
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_wrenches.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    mismatches++;
                end
                else
                begin
                    w = expected_wrenches.pop_front();
                    check_field("thrust_force", w.thrust, thrust_force);
                    check_field("torque_first", w.tq_first, torque_first);
                    check_field("torque_second", w.tq_second, torque_second);
                    check_field("torque_third", w.tq_third, torque_third);
                    check_field("saturated", w.sat, saturated);
                    check_field("status", w.code, status);
                end
            end
            if (in_valid && in_ready)
            begin
                take_element(enable, state_value, reference_value, last);
            end
        end
    end

    // Driver: present the next pending element, with random gaps
    always @(posedge clk)
    begin
        element_t e;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                e = pending_elements.pop_front();
                in_valid        <= 1'b1;
                enable          <= e.enable;
                state_value     <= e.state_v;
                reference_value <= e.ref_v;
                last            <= e.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic set_limits(input logic [31:0] mass_q, input logic [31:0] grav_q,
                              input logic [31:0] fmin_q, input logic [31:0] fmax_q,
                              input logic [31:0] torque_q);
        logic [2:0]  idx [5];
        logic [31:0] val [5];
        idx = '{CFG_MASS, CFG_GRAVITY, CFG_FORCE_MIN, CFG_FORCE_MAX, CFG_TORQUE_LIMIT};
        val = '{mass_q, grav_q, fmin_q, fmax_q, torque_q};
        for (int k = 0; k < 5; k++)
        begin
            @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index    <= idx[k];
            cfg_data     <= val[k];
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until everything sent has come back, then let the pipe empty
    task automatic drain();
        @(negedge clk);
        while (pending_elements.size() != 0 || in_valid || expected_wrenches.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] any_q16();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom;
            default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // Small error around the reference: +-64, +-512 or +-4096 LSB
    function automatic logic [31:0] small_offset();
        int unsigned span;
        span = 64 << (3 * $urandom_range(2));
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic push_vector(input int len, input bit en, input bit quiet);
        element_t e;
        for (int i = 0; i < len; i++)
        begin
            e.ref_v   = any_q16();
            e.state_v = quiet ? e.ref_v + small_offset() : any_q16();
            e.last    = (i == len - 1);
            e.enable  = e.last ? en : 1'($urandom_range(1));
            pending_elements.push_back(e);
        end
    endtask

    // Mostly full vectors; some short, some overlong, a few disabled
    task automatic run_random_phase(input int target);
        int pushed;
        int len;
        int pick;
        pushed = 0;
        while (pushed < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                len = STATE_COUNT;
            else if (pick < 88)
                len = $urandom_range(STATE_COUNT - 1, 1);
            else
                len = $urandom_range(16, STATE_COUNT + 1);
            push_vector(len, $urandom_range(99) >= 8, $urandom_range(99) < 70);
            pushed += len;
        end
    endtask

    task automatic pick_limits(input int kind);
        case (kind)
            0: set_limits($urandom_range(131072, 32768), $urandom_range(658637, 625869),
                          $urandom_range(65536), $urandom_range(2097152, 1048576),
                          $urandom_range(1048576, 131072));
            1: set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF);
            2: set_limits(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h0000_0001);
            default: set_limits($urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    // Stimulus sequence
    initial
    begin
        element_t e;
        int       kinds [6];
        kinds = '{0, 1, 0, 2, 0, 3};
        send_idle_pct = 15;
        recv_idle_pct = 46;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full vector mixing saturating, zero and small errors at reset limits
        for (int i = 0; i < STATE_COUNT; i++)
        begin
            case (i % 4)
                0:       begin e.state_v = 32'h7FFF_FFFF; e.ref_v = 32'h8000_0000; end
                1:       begin e.state_v = 32'h8000_0000; e.ref_v = 32'h7FFF_FFFF; end
                2:       begin e.state_v = 32'h0000_0000; e.ref_v = 32'h0000_0000; end
                default: begin e.state_v = 32'hFFFF_FFFF; e.ref_v = 32'h0000_0001; end
            endcase
            e.enable = 1'b1;
            e.last   = (i == STATE_COUNT - 1);
            pending_elements.push_back(e);
        end
        // Last on the first element: length mismatch, then disabled
        push_vector(1, 1'b1, 1'b1);
        push_vector(1, 1'b0, 1'b1);
        drain();

        // Zero torque limit, then force_max below force_min
        set_limits(32'd65536, 32'd642253, 32'd0, 32'd1638400, 32'd0);
        push_vector(1, 1'b1, 1'b1);
        drain();
        set_limits(32'd65536, 32'd642253, 32'd65536, 32'd0, 32'd524288);
        push_vector(1, 1'b1, 1'b1);
        drain();

        // Random phases: idle pattern changes every two phases
        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 15;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_limits(kinds[p]);
            run_random_phase(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
